FILE: rtl/spa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants and the arctangent table for the sky-plane angle pipeline.
// ----------------------------------------------------------------------------
package spa_pkg;

  // Internal CORDIC rotation width; sin/cos leave as Q30 in SinW bits.
  localparam int TrigW = 34;
  localparam int SinW  = 32;
  localparam logic signed [TrigW-1:0] CordicK = 34'sd652032874;

  // Vectoring: operands are normalized until the larger magnitude lies in [2^39, 2^40).
  localparam int NormLimitLog = 40;
  localparam int NormSteps    = 6;
  localparam int VecW         = 44;

  // atan(2^-i) as a 32-bit binary angle.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/sky_plane_polarization_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sky_plane_polarization_angle
// Polarization position angle of a field vector on the sky plane.
// ----------------------------------------------------------------------------
// One beat in (theta, phi, vec_x/y/z), one beat out (pol_angle) per beat, in
// order. The pipeline takes a new beat every cycle. On its way from input
// accept to the result showing at the output, a beat passes through a
// sin/cos CORDIC per angle (prefold + one stage per iteration), four
// multiply/round stages, a fold and six normalize steps, the vectoring CORDIC
// and a rounding register, then a two-entry output buffer. All stages advance
// together while the output buffer has room, so the input keeps being taken
// while at most one finished result waits downstream; with two waiting the
// whole pipeline holds. Angles are binary angles (2^ANGLE_BITS = one turn);
// both zero projections give angle 0.
// ----------------------------------------------------------------------------
module sky_plane_polarization_angle #(
  parameter int ANGLE_BITS     = 16,
  parameter int COMPONENT_BITS = 24,
  parameter int CORDIC_STAGES  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ANGLE_BITS-1:0]            theta_i,
  input  logic [ANGLE_BITS-1:0]            phi_i,
  input  logic signed [COMPONENT_BITS-1:0] vec_x_i,
  input  logic signed [COMPONENT_BITS-1:0] vec_y_i,
  input  logic signed [COMPONENT_BITS-1:0] vec_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ANGLE_BITS-1:0]            pol_angle_o
);
  import spa_pkg::*;

  localparam int TrigLat = CORDIC_STAGES + 1;
  localparam int NumStg  = 2 * CORDIC_STAGES + 13;

  // Pipeline control: one global advance, valid bits ride alongside.
  logic              en;
  logic [NumStg-1:0] vld_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              push, pop;

  // Datapath links.
  logic signed [SinW-1:0]           sin_t, cos_t, sin_p, cos_p;
  logic signed [COMPONENT_BITS-1:0] vx_q [TrigLat];
  logic signed [COMPONENT_BITS-1:0] vy_q [TrigLat];
  logic signed [COMPONENT_BITS-1:0] vz_q [TrigLat];
  logic signed [COMPONENT_BITS+1:0] xc, yc;
  logic signed [VecW-1:0]           nx, ny;
  logic                             n_half, n_zero;
  logic [ANGLE_BITS-1:0]            angle;

  // Output buffer.
  logic [ANGLE_BITS-1:0] head_q, head_d;
  logic [ANGLE_BITS-1:0] skid_q, skid_d;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], in_valid_i};
    end
  end

  spa_sincos #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_trig_theta (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(theta_i),
    .sin_o  (sin_t),
    .cos_o  (cos_t)
  );

  spa_sincos #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_trig_phi (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(phi_i),
    .sin_o  (sin_p),
    .cos_o  (cos_p)
  );

  // Components wait alongside the sin/cos pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q[0] <= vec_x_i;
      vy_q[0] <= vec_y_i;
      vz_q[0] <= vec_z_i;
      for (int k = 1; k < TrigLat; k++) begin
        vx_q[k] <= vx_q[k-1];
        vy_q[k] <= vy_q[k-1];
        vz_q[k] <= vz_q[k-1];
      end
    end
  end

  spa_proj #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_proj (
    .clk_i  (clk_i),
    .en_i   (en),
    .sin_t_i(sin_t),
    .cos_t_i(cos_t),
    .sin_p_i(sin_p),
    .cos_p_i(cos_p),
    .vx_i   (vx_q[TrigLat-1]),
    .vy_i   (vy_q[TrigLat-1]),
    .vz_i   (vz_q[TrigLat-1]),
    .xc_o   (xc),
    .yc_o   (yc)
  );

  spa_norm #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_norm (
    .clk_i (clk_i),
    .en_i  (en),
    .xc_i  (xc),
    .yc_i  (yc),
    .x_o   (nx),
    .y_o   (ny),
    .half_o(n_half),
    .zero_o(n_zero)
  );

  spa_vector #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_vector (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (nx),
    .y_i    (ny),
    .half_i (n_half),
    .zero_i (n_zero),
    .angle_o(angle)
  );

  // Two-entry output buffer; pipeline pushes only while it has room.
  assign push = en & vld_q[NumStg-1];
  assign pop  = out_valid_o & out_ready_i;

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    skid_d = skid_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd0) begin
        head_d = angle;
      end else begin
        skid_d = angle;
      end
    end else if (pop && !push) begin
      cnt_d  = cnt_q - 2'd1;
      head_d = skid_q;
    end else if (pop && push) begin
      head_d = angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign pol_angle_o = head_q;

endmodule

FILE: rtl/spa_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_sincos
// Pipelined CORDIC rotation: binary angle in, Q30 sine and cosine out.
// ----------------------------------------------------------------------------
module spa_sincos #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [ANGLE_BITS-1:0]              angle_i,
  output logic signed [spa_pkg::SinW-1:0]    sin_o,
  output logic signed [spa_pkg::SinW-1:0]    cos_o
);
  import spa_pkg::*;

  logic [31:0]             ang;
  logic [31:0]             shifted;
  logic [31:0]             ang_f;
  logic signed [TrigW-1:0] x0_d;
  logic signed [TrigW-1:0] z0_d;

  logic signed [TrigW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [TrigW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [TrigW-1:0] z_q [CORDIC_STAGES+1];

  // Fold into [-pi/2, pi/2) by a half turn, starting from -K when folded, else K.
  always_comb begin
    ang     = {angle_i, {(32-ANGLE_BITS){1'b0}}};
    shifted = ang + 32'h4000_0000;
    if (shifted[31]) begin
      ang_f = ang - 32'h8000_0000;
      x0_d  = -CordicK;
    end else begin
      ang_f = ang;
      x0_d  = CordicK;
    end
    z0_d = {{(TrigW-32){ang_f[31]}}, ang_f};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0_d;
      y_q[0] <= '0;
      z_q[0] <= z0_d;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [TrigW-1:0] dx;
    logic signed [TrigW-1:0] dy;
    logic signed [TrigW-1:0] at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = {{(TrigW-32){1'b0}}, atan_turn(5'(i))};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][TrigW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  assign sin_o = y_q[CORDIC_STAGES][SinW-1:0];
  assign cos_o = x_q[CORDIC_STAGES][SinW-1:0];

endmodule

FILE: rtl/spa_proj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_proj
// Projects the field vector on e_theta and e_phi; four register stages.
// ----------------------------------------------------------------------------
module spa_proj #(
  parameter int COMPONENT_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [spa_pkg::SinW-1:0]     sin_t_i,
  input  logic signed [spa_pkg::SinW-1:0]     cos_t_i,
  input  logic signed [spa_pkg::SinW-1:0]     sin_p_i,
  input  logic signed [spa_pkg::SinW-1:0]     cos_p_i,
  input  logic signed [COMPONENT_BITS-1:0]    vx_i,
  input  logic signed [COMPONENT_BITS-1:0]    vy_i,
  input  logic signed [COMPONENT_BITS-1:0]    vz_i,
  output logic signed [COMPONENT_BITS+1:0]    xc_o,
  output logic signed [COMPONENT_BITS+1:0]    yc_o
);
  import spa_pkg::*;

  localparam int AW = COMPONENT_BITS + 2;
  localparam int PW = SinW + COMPONENT_BITS;
  localparam int QW = PW + 2;

  localparam logic signed [PW:0] HalfP = (PW+1)'(1) <<< 29;
  localparam logic signed [QW:0] HalfQ = (QW+1)'(1) <<< 29;

  // stage 1
  logic signed [PW-1:0]             p1_q, p2_q, p3_q, p4_q;
  logic signed [SinW-1:0]           st1_q, ct1_q;
  logic signed [COMPONENT_BITS-1:0] vz1_q;
  // stage 2
  logic signed [PW:0]               a_sum, x_sum;
  logic signed [AW-1:0]             a_d, x2_d;
  logic signed [AW-1:0]             a2_q, x2_q;
  logic signed [SinW-1:0]           st2_q, ct2_q;
  logic signed [COMPONENT_BITS-1:0] vz2_q;
  // stage 3
  logic signed [QW-1:0]             p5_q, p6_q;
  logic signed [AW-1:0]             x3_q;
  // stage 4
  logic signed [QW:0]               y_sum;
  logic signed [AW-1:0]             y4_d;
  logic signed [AW-1:0]             x4_q, y4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= PW'(cos_p_i * vx_i);
      p2_q  <= PW'(sin_p_i * vy_i);
      p3_q  <= PW'(sin_p_i * vx_i);
      p4_q  <= PW'(cos_p_i * vy_i);
      st1_q <= sin_t_i;
      ct1_q <= cos_t_i;
      vz1_q <= vz_i;
    end
  end

  // Round Q30 to integer: add half, floor.
  always_comb begin
    a_sum = (PW+1)'(p1_q) + (PW+1)'(p2_q) + HalfP;
    x_sum = (PW+1)'(p3_q) - (PW+1)'(p4_q) + HalfP;
    a_d   = a_sum[30 +: AW];
    x2_d  = x_sum[30 +: AW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q  <= a_d;
      x2_q  <= x2_d;
      st2_q <= st1_q;
      ct2_q <= ct1_q;
      vz2_q <= vz1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p5_q <= QW'(st2_q * vz2_q);
      p6_q <= QW'(ct2_q * a2_q);
      x3_q <= x2_q;
    end
  end

  always_comb begin
    y_sum = (QW+1)'(p5_q) - (QW+1)'(p6_q) + HalfQ;
    y4_d  = y_sum[30 +: AW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x4_q <= x3_q;
      y4_q <= y4_d;
    end
  end

  assign xc_o = x4_q;
  assign yc_o = y4_q;

endmodule

FILE: rtl/spa_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_norm
// Folds to x >= 0, then normalizes by binary shift steps, one per stage.
// ----------------------------------------------------------------------------
module spa_norm #(
  parameter int COMPONENT_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [COMPONENT_BITS+1:0]   xc_i,
  input  logic signed [COMPONENT_BITS+1:0]   yc_i,
  output logic signed [spa_pkg::VecW-1:0]    x_o,
  output logic signed [spa_pkg::VecW-1:0]    y_o,
  output logic                               half_o,
  output logic                               zero_o
);
  import spa_pkg::*;

  localparam int AW = COMPONENT_BITS + 2;

  logic signed [VecW-1:0] xe, ye;

  logic signed [VecW-1:0] x_q    [NormSteps+1];
  logic signed [VecW-1:0] y_q    [NormSteps+1];
  logic                   half_q [NormSteps+1];
  logic                   zero_q [NormSteps+1];

  assign xe = {{(VecW-AW){xc_i[AW-1]}}, xc_i};
  assign ye = {{(VecW-AW){yc_i[AW-1]}}, yc_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      half_q[0] <= xc_i[AW-1];
      zero_q[0] <= (xc_i == '0) && (yc_i == '0);
      if (xc_i[AW-1]) begin
        x_q[0] <= -xe;
        y_q[0] <= -ye;
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
      end
    end
  end

  for (genvar j = 0; j < NormSteps; j++) begin : g_step
    localparam int Sh = 1 << (NormSteps - 1 - j);
    logic [VecW-1:0] ay;
    logic [VecW-1:0] mag;
    logic            small_mag;
    assign ay        = y_q[j][VecW-1] ? VecW'(-y_q[j]) : VecW'(y_q[j]);
    assign mag       = VecW'(x_q[j]) | ay;
    assign small_mag = (mag[VecW-1:NormLimitLog-Sh] == '0);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        half_q[j+1] <= half_q[j];
        zero_q[j+1] <= zero_q[j];
        if (small_mag) begin
          x_q[j+1] <= x_q[j] <<< Sh;
          y_q[j+1] <= y_q[j] <<< Sh;
        end else begin
          x_q[j+1] <= x_q[j];
          y_q[j+1] <= y_q[j];
        end
      end
    end
  end

  assign x_o    = x_q[NormSteps];
  assign y_o    = y_q[NormSteps];
  assign half_o = half_q[NormSteps];
  assign zero_o = zero_q[NormSteps];

endmodule

FILE: rtl/spa_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_vector
// Pipelined CORDIC vectoring and output rounding to the binary angle.
// ----------------------------------------------------------------------------
module spa_vector #(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [spa_pkg::VecW-1:0] x_i,
  input  logic signed [spa_pkg::VecW-1:0] y_i,
  input  logic                            half_i,
  input  logic                            zero_i,
  output logic [ANGLE_BITS-1:0]           angle_o
);
  import spa_pkg::*;

  logic signed [VecW-1:0] x_q    [CORDIC_STAGES];
  logic signed [VecW-1:0] y_q    [CORDIC_STAGES];
  logic [31:0]            z_q    [CORDIC_STAGES];
  logic                   zero_q [CORDIC_STAGES];
  logic [31:0]            z_rnd;
  logic [ANGLE_BITS-1:0]  angle_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [VecW-1:0] xs, ys;
    logic [31:0]            zs;
    logic                   zr;
    logic [31:0]            at;
    if (i == 0) begin : g_first
      assign xs = x_i;
      assign ys = y_i;
      assign zs = half_i ? 32'h8000_0000 : 32'h0000_0000;
      assign zr = zero_i;
    end else begin : g_next
      assign xs = x_q[i-1];
      assign ys = y_q[i-1];
      assign zs = z_q[i-1];
      assign zr = zero_q[i-1];
    end
    assign at = atan_turn(5'(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i] <= zr;
        if (!ys[VecW-1]) begin
          x_q[i] <= xs + (ys >>> i);
          y_q[i] <= ys - (xs >>> i);
          z_q[i] <= zs + at;
        end else begin
          x_q[i] <= xs - (ys >>> i);
          y_q[i] <= ys + (xs >>> i);
          z_q[i] <= zs - at;
        end
      end
    end
  end

  // Round half an output unit up, keep the top bits; wraps modulo a turn.
  assign z_rnd = z_q[CORDIC_STAGES-1] + (32'd1 << (31 - ANGLE_BITS));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zero_q[CORDIC_STAGES-1] ? '0 : z_rnd[31 -: ANGLE_BITS];
    end
  end

  assign angle_o = angle_q;

endmodule
